@@ rtl/core/mandelbrot_escape_time_unit_macros.svh @@
// Assertion macros shared by the escape-time core modules.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef MANDELBROT_ESCAPE_TIME_UNIT_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MET_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("escape-time core: implication check failed");

// Next-cycle implication, disabled during reset.
`define MET_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("escape-time core: next-cycle check failed");

`endif

@@ rtl/core/met_pkg.sv @@
// Shared types and constants for the escape-time core.
// No dependencies; used by the controller, the datapath and the top level.
package met_pkg;

    localparam int CW             = 31;   // width of c_real and c_imag
    localparam int CNTW           = 16;   // width of iteration counts
    localparam int MAX_ITER_RESET = 500;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_SQUARE
    } state_t;

    typedef struct packed {
        logic load;      // take c, clear z
        logic square;    // form re*re, im*im, re*im
        logic update;    // z = z*z + c, count up
        logic capture;   // latch the result
    } cmd_t;

    typedef struct packed {
        logic escape_hit;
        logic limit_hit;
    } status_t;

endpackage

@@ rtl/core/mandelbrot_escape_time_unit.sv @@
// Mandelbrot escape-time unit. Pulse start while busy is low to hand in a
// point c; busy rises on the next cycle. Each iteration has two phases: the
// three registered multipliers (re*re, im*im, re*im) in the square state, then
// the escape compare and the z update in the update state. A point that
// escapes, or runs to the limit N = max_iterations, gives its result
// as a one-cycle done strobe; the next point may be started in
// the cycle the strobe shows. The receiver cannot hold results off, so a
// result not taken while done is high is gone. Write max_iterations only
// while the unit is idle; cfg_ready is always high.
`include "mandelbrot_escape_time_unit_macros.svh"

module mandelbrot_escape_time_unit #(
    parameter int FRAC_BITS = 28
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    output logic                          done,
    input  logic signed [met_pkg::CW-1:0] c_real,
    input  logic signed [met_pkg::CW-1:0] c_imag,
    output logic [met_pkg::CNTW-1:0]      escape_count,
    output logic                          escaped,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [met_pkg::CNTW-1:0]      cfg_data
);
    import met_pkg::*;

    cmd_t            cmd;
    status_t         status;
    logic [CNTW-1:0] max_iter_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= CNTW'(MAX_ITER_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_iter_reg <= cfg_data;
        end
    end

    met_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd),
        .status (status)
    );

    met_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .c_real         (c_real),
        .c_imag         (c_imag),
        .max_iterations (max_iter_reg),
        .escape_count   (escape_count),
        .escaped        (escaped)
    );

    `MET_ASSERT_IMPL(a_escape_flag, done, escaped == (escape_count != '0))
    `MET_ASSERT_IMPL(a_no_result_when_busy, done, !busy)
    `MET_ASSERT_IMPL(a_count_in_limit, done, escape_count <= max_iter_reg)

endmodule

@@ rtl/core/met_datapath.sv @@
// Datapath of the escape-time core: z registers, three multipliers,
// escape compare, iteration counter and result registers. Uses met_pkg.
module met_datapath #(
    parameter int FRAC_BITS = 28
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  met_pkg::cmd_t                 cmd,
    output met_pkg::status_t              status,
    input  logic signed [met_pkg::CW-1:0] c_real,
    input  logic signed [met_pkg::CW-1:0] c_imag,
    input  logic [met_pkg::CNTW-1:0]      max_iterations,
    output logic [met_pkg::CNTW-1:0]      escape_count,
    output logic                          escaped
);
    import met_pkg::*;

    // z stays below |c| + 4 in magnitude, so one sign bit over max(c, 3.FRAC)
    localparam int ZW  = ((FRAC_BITS + 3 > CW) ? FRAC_BITS + 3 : CW) + 1;
    localparam int SQW = 2 * ZW - FRAC_BITS;
    localparam logic [SQW:0] FOUR = (SQW + 1)'(4) << FRAC_BITS;

    logic signed [CW-1:0]     cr_reg, ci_reg;
    logic signed [ZW-1:0]     re_reg, im_reg;
    logic signed [ZW-1:0]     re_next, im_next;
    logic [SQW-1:0]           sr_reg, si_reg;
    logic signed [2*ZW-1:0]   p_reg;
    logic signed [2*ZW-1:0]   sq_re, sq_im, prod;
    logic [CNTW-1:0]          n_reg;
    logic [SQW:0]             mod_sum;
    logic signed [SQW+1:0]    re_wide;
    logic [CNTW-1:0]          count_reg;
    logic                     escaped_reg;

    assign sq_re = re_reg * re_reg;
    assign sq_im = im_reg * im_reg;
    assign prod  = re_reg * im_reg;

    assign mod_sum = {1'b0, sr_reg} + {1'b0, si_reg};

    // Truncation below is exact whenever the point has not escaped yet.
    assign re_wide = $signed({2'b00, sr_reg}) - $signed({2'b00, si_reg})
                   + $signed({{(SQW + 2 - CW){cr_reg[CW-1]}}, cr_reg});
    assign re_next = re_wide[ZW-1:0];
    assign im_next = $signed(p_reg[ZW+FRAC_BITS-2:FRAC_BITS-1])
                   + $signed({{(ZW - CW){ci_reg[CW-1]}}, ci_reg});

    assign status.escape_hit = (n_reg != '0) && (mod_sum >= FOUR);
    assign status.limit_hit  = (n_reg == max_iterations);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr_reg <= '0;
            ci_reg <= '0;
            re_reg <= '0;
            im_reg <= '0;
            sr_reg <= '0;
            si_reg <= '0;
            p_reg  <= '0;
            n_reg  <= '0;
        end
        else if (cmd.load)
        begin
            cr_reg <= c_real;
            ci_reg <= c_imag;
            re_reg <= '0;
            im_reg <= '0;
            sr_reg <= '0;
            si_reg <= '0;
            p_reg  <= '0;
            n_reg  <= '0;
        end
        else if (cmd.square)
        begin
            sr_reg <= sq_re[2*ZW-1:FRAC_BITS];
            si_reg <= sq_im[2*ZW-1:FRAC_BITS];
            p_reg  <= prod;
        end
        else if (cmd.update)
        begin
            re_reg <= re_next;
            im_reg <= im_next;
            n_reg  <= n_reg + CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            escaped_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            count_reg   <= status.escape_hit ? n_reg : '0;
            escaped_reg <= status.escape_hit;
        end
    end

    assign escape_count = count_reg;
    assign escaped      = escaped_reg;

endmodule

@@ rtl/core/met_controller.sv @@
// Controller of the escape-time core: sequences load, square and update
// phases and raises the done strobe. Uses met_pkg and the assertion macros.
`include "mandelbrot_escape_time_unit_macros.svh"

module met_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output logic             done,
    output met_pkg::cmd_t    cmd,
    input  met_pkg::status_t status
);
    import met_pkg::*;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                // test the previous z first, then stop at the limit
                if (status.escape_hit || status.limit_hit)
                begin
                    cmd.capture = 1'b1;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.update = 1'b1;
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = S_UPDATE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    `MET_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)
    `MET_ASSERT_IMPL(a_done_after_update, done, $past(state_reg == S_UPDATE))
    `MET_ASSERT_IMPL(a_one_command, 1'b1, $onehot0({cmd.load, cmd.square, cmd.update, cmd.capture}))
    `MET_ASSERT_NEXT(a_square_then_update, state_reg == S_SQUARE, state_reg == S_UPDATE)

endmodule
